@@ rtl/elmp_pkg.sv @@
// shared types and character constants for the ethers line parser
package elmp_pkg;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_X_LO  = 8'h78;

	localparam int          MAC_W      = 48;
	localparam int          GVAL_W     = 9;
	localparam logic [2:0]  LAST_GROUP = 3'd5;

	// first character class of a group
	localparam logic [1:0] FC_COLON = 2'd0;
	localparam logic [1:0] FC_BLANK = 2'd1;
	localparam logic [1:0] FC_OTHER = 2'd2;

	// classified character as it travels from front to back
	typedef struct packed {
		logic [7:0] ch;
		logic       blank;
		logic       odd_ws;
		logic       nl;
		logic       colon;
		logic       plus;
		logic       minus;
		logic       x_ch;
		logic       hex_ok;
		logic [3:0] hex_val;
	} chr_entry_t;

	// one result item
	typedef struct packed {
		logic             kind;
		logic [7:0]       out_char;
		logic             status;
		logic [MAC_W-1:0] mac;
	} res_t;

	typedef enum logic [9:0] {
		PH_LEAD  = 10'b00_0000_0001,
		PH_FIRST = 10'b00_0000_0010,
		PH_WS    = 10'b00_0000_0100,
		PH_SIGN  = 10'b00_0000_1000,
		PH_ZERO  = 10'b00_0001_0000,
		PH_X     = 10'b00_0010_0000,
		PH_DIG   = 10'b00_0100_0000,
		PH_HSKIP = 10'b00_1000_0000,
		PH_HOST  = 10'b01_0000_0000,
		PH_DONE  = 10'b10_0000_0000
	} phase_t;

endpackage

@@ rtl/elmp_front.sv @@
// front end: classifies each incoming character for the parser
module elmp_front
	import elmp_pkg::*;
(
	input  logic [7:0] ch,
	output chr_entry_t entry
);

	always_comb begin
		entry        = '0;
		entry.ch     = ch;
		entry.blank  = (ch == CH_SPACE) || (ch == CH_TAB);
		entry.odd_ws = (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);
		entry.nl     = (ch == CH_NL);
		entry.colon  = (ch == CH_COLON);
		entry.plus   = (ch == CH_PLUS);
		entry.minus  = (ch == CH_MINUS);
		entry.x_ch   = (ch == CH_X_LO) || (ch == CH_X_UP);
		// hex digit decode
		if (ch >= 8'h30 && ch <= 8'h39) begin
			entry.hex_ok  = 1'b1;
			entry.hex_val = 4'(ch - 8'h30);
		end else if (ch >= 8'h61 && ch <= 8'h66) begin
			entry.hex_ok  = 1'b1;
			entry.hex_val = 4'(ch - 8'h57);
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			entry.hex_ok  = 1'b1;
			entry.hex_val = 4'(ch - 8'h37);
		end
	end

endmodule

@@ rtl/elmp_queue.sv @@
// small fifo of classified characters between front and back
module elmp_queue
	import elmp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  chr_entry_t                 push_data,
	input  logic                       pop,
	output chr_entry_t                 pop_data,
	output logic                       not_empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	chr_entry_t       stor_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(DEPTH-1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) stor_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign pop_data  = stor_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

endmodule

@@ rtl/elmp_back.sv @@
// back end: hex group parser state machine with registered result
module elmp_back
	import elmp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  chr_entry_t q_data,
	output logic       q_pop,
	output logic       res_valid,
	input  logic       res_stall,
	output res_t       res
);

	phase_t            phase_q, phase_n;
	logic [2:0]        gidx_q, gidx_n;
	logic [GVAL_W-1:0] gval_q, gval_n;
	logic              f_sign_q, f_sign_n;
	logic              f_neg_q, f_neg_n;
	logic              f_dig_q, f_dig_n;
	logic              f_odd_q, f_odd_n;
	logic [1:0]        fc_q, fc_n;
	logic [MAC_W-1:0]  addr_q, addr_n;
	logic              out_valid_q;
	res_t              out_q;
	res_t              res_n;
	logic              emit;
	logic              ready;

	assign ready = !out_valid_q || !res_stall;
	assign q_pop = q_valid && ready;

	// saturating value*16 + digit
	function automatic logic [GVAL_W-1:0] add_dig(input logic [GVAL_W-1:0] v,
		input logic [3:0] d);
		add_dig = (v[GVAL_W-1:4] != '0) ? GVAL_W'(256) : {1'b0, v[3:0], d};
	endfunction

	always_comb begin
		phase_t grp_ph;
		logic   run;
		logic   end_req;
		logic   fail;
		logic   succ;
		logic   last;
		logic   bad;
		logic   term;

		phase_n  = phase_q;
		gidx_n   = gidx_q;
		gval_n   = gval_q;
		f_sign_n = f_sign_q;
		f_neg_n  = f_neg_q;
		f_dig_n  = f_dig_q;
		f_odd_n  = f_odd_q;
		fc_n     = fc_q;
		addr_n   = addr_q;
		res_n    = '0;
		emit     = 1'b0;
		grp_ph   = phase_q;
		run      = 1'b0;
		end_req  = 1'b0;
		fail     = 1'b0;
		succ     = 1'b0;
		last     = (gidx_q >= LAST_GROUP);
		bad      = 1'b0;
		term     = 1'b0;

		if (q_pop) begin
			unique case (phase_q)
				PH_LEAD, PH_FIRST: begin
					if (!(phase_q == PH_LEAD && q_data.blank)) begin
						fc_n   = q_data.colon ? FC_COLON : (q_data.blank ? FC_BLANK : FC_OTHER);
						grp_ph = PH_WS;
						run    = 1'b1;
					end
				end
				PH_WS, PH_SIGN, PH_ZERO, PH_X, PH_DIG: run = 1'b1;
				PH_HSKIP: begin
					if (q_data.odd_ws || q_data.nl) begin
						succ = 1'b1;
					end else if (!q_data.blank) begin
						phase_n        = PH_HOST;
						emit           = 1'b1;
						res_n.out_char = q_data.ch;
					end
				end
				PH_HOST: begin
					if (q_data.blank || q_data.odd_ws || q_data.nl) begin
						succ = 1'b1;
					end else begin
						emit           = 1'b1;
						res_n.out_char = q_data.ch;
					end
				end
				PH_DONE: ;
				default: ;
			endcase

			if (run) begin
				unique case (grp_ph)
					PH_WS: begin
						if (q_data.blank) begin
							phase_n = PH_WS;
						end else if (q_data.odd_ws) begin
							f_odd_n = 1'b1;
							phase_n = PH_WS;
						end else if (q_data.plus || q_data.minus) begin
							f_sign_n = 1'b1;
							f_neg_n  = q_data.minus;
							phase_n  = PH_SIGN;
						end else if (q_data.hex_ok) begin
							gval_n  = add_dig(gval_q, q_data.hex_val);
							f_dig_n = 1'b1;
							phase_n = (q_data.hex_val == 4'd0) ? PH_ZERO : PH_DIG;
						end else begin
							end_req = 1'b1;
						end
					end
					PH_SIGN: begin
						if (q_data.hex_ok) begin
							gval_n  = add_dig(gval_q, q_data.hex_val);
							f_dig_n = 1'b1;
							phase_n = (q_data.hex_val == 4'd0) ? PH_ZERO : PH_DIG;
						end else begin
							end_req = 1'b1;
						end
					end
					PH_ZERO: begin
						if (q_data.x_ch) begin
							phase_n = PH_X;
						end else if (q_data.hex_ok) begin
							gval_n  = add_dig(gval_q, q_data.hex_val);
							f_dig_n = 1'b1;
							phase_n = PH_DIG;
						end else begin
							end_req = 1'b1;
						end
					end
					PH_X: begin
						if (q_data.hex_ok) begin
							gval_n  = add_dig(gval_q, q_data.hex_val);
							f_dig_n = 1'b1;
							phase_n = PH_DIG;
						end else begin
							fail = 1'b1;
						end
					end
					default: begin
						if (q_data.hex_ok) begin
							gval_n  = add_dig(gval_q, q_data.hex_val);
							f_dig_n = 1'b1;
						end else begin
							end_req = 1'b1;
						end
					end
				endcase
			end

			// group terminated by the current character
			if (end_req) begin
				if (f_dig_q) begin
					bad  = gval_q[GVAL_W-1] || (f_neg_q && gval_q != '0);
					term = last ? q_data.blank : q_data.colon;
					if (bad || !term) begin
						fail = 1'b1;
					end else begin
						addr_n = {addr_q[MAC_W-9:0], gval_q[7:0]};
						if (!last) begin
							gidx_n   = gidx_q + 1'b1;
							gval_n   = '0;
							f_sign_n = 1'b0;
							f_neg_n  = 1'b0;
							f_dig_n  = 1'b0;
							f_odd_n  = 1'b0;
							fc_n     = FC_COLON;
							phase_n  = PH_FIRST;
						end else begin
							phase_n = PH_HSKIP;
						end
					end
				end else if (!last) begin
					if (fc_n != FC_COLON) begin
						fail = 1'b1;
					end else begin
						addr_n   = {addr_q[MAC_W-9:0], 8'h00};
						gidx_n   = gidx_q + 1'b1;
						gval_n   = '0;
						f_sign_n = 1'b0;
						f_neg_n  = 1'b0;
						f_dig_n  = 1'b0;
						f_odd_n  = 1'b0;
						fc_n     = FC_COLON;
						phase_n  = PH_FIRST;
					end
				end else if (fc_n != FC_BLANK || f_sign_q) begin
					fail = 1'b1;
				end else begin
					addr_n = {addr_q[MAC_W-9:0], 8'h00};
					if (f_odd_q || q_data.blank || q_data.odd_ws || q_data.nl) begin
						succ = 1'b1;
					end else begin
						phase_n        = PH_HOST;
						emit           = 1'b1;
						res_n.out_char = q_data.ch;
					end
				end
			end

			if (fail || succ) begin
				emit         = 1'b1;
				res_n.kind   = 1'b1;
				res_n.status = fail;
				res_n.mac    = fail ? '0 : addr_n;
				phase_n      = PH_DONE;
			end

			// newline always restarts the line
			if (q_data.nl) begin
				phase_n  = PH_LEAD;
				gidx_n   = '0;
				gval_n   = '0;
				f_sign_n = 1'b0;
				f_neg_n  = 1'b0;
				f_dig_n  = 1'b0;
				f_odd_n  = 1'b0;
				fc_n     = FC_COLON;
				addr_n   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			gidx_q      <= '0;
			gval_q      <= '0;
			f_sign_q    <= 1'b0;
			f_neg_q     <= 1'b0;
			f_dig_q     <= 1'b0;
			f_odd_q     <= 1'b0;
			fc_q        <= FC_COLON;
			addr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			gidx_q   <= gidx_n;
			gval_q   <= gval_n;
			f_sign_q <= f_sign_n;
			f_neg_q  <= f_neg_n;
			f_dig_q  <= f_dig_n;
			f_odd_q  <= f_odd_n;
			fc_q     <= fc_n;
			addr_q   <= addr_n;
			if (ready) out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && emit) out_q <= res_n;
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

@@ rtl/ethers_line_mac_parser.sv @@
// top level of the ethers line mac address parser
//
// usage:
//   input channel: one character per request on ch, qualified by ch_valid and
//   held back by ch_stall. a newline (0x0a) ends the line and restarts parsing.
//   result channel: res_valid with kind, out_char, status and mac_address.
//   kind 0 carries one hostname character, kind 1 the final line result
//   (status 0 success with the six parsed bytes, status 1 malformed line).
//   at most one result per character; many characters give none.
// path: an accepted character is written into the queue, and the parser
//   step then loads its result into the output register.
// throughput: one character per cycle unless ch_stall is high; the parser
//   takes one queue entry per cycle whenever the output register is empty
//   or being taken.
// stall: while res_stall holds, the result stays put and the parser stops;
//   the front keeps taking characters until QUEUE_DEPTH of them wait, then
//   raises ch_stall.
// reset: arst_n empties the queue, drops res_valid and returns the parser
//   to the leading whitespace skip with a cleared address.
module ethers_line_mac_parser
	import elmp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ch_valid,
	output logic        ch_stall,
	input  logic [7:0]  ch,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        kind,
	output logic [7:0]  out_char,
	output logic        status,
	output logic [47:0] mac_address
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

	chr_entry_t       front_entry;   // classified incoming character
	chr_entry_t       q_head;        // oldest waiting character
	logic             q_push;
	logic             q_pop;
	logic             q_not_empty;
	logic [CNT_W-1:0] q_count;
	res_t             res;

	// front: character classification
	elmp_front u_front (
		.ch    (ch),
		.entry (front_entry)
	);

	// stall only when every queue slot is taken
	assign ch_stall = (q_count == CNT_W'(QUEUE_DEPTH));
	assign q_push   = ch_valid && !ch_stall;

	elmp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (front_entry),
		.pop       (q_pop),
		.pop_data  (q_head),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	// back: group parser and result register
	elmp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_data    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	assign kind        = res.kind;
	assign out_char    = res.out_char;
	assign status      = res.status;
	assign mac_address = res.mac;

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |-> !q_pop)
		else $error("parser advanced while result stalled");

	a_char_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !kind) |-> (!status && mac_address == '0))
		else $error("hostname character with status fields set");

	a_fail_zero_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && kind && status) |-> (mac_address == '0 && out_char == '0))
		else $error("failure result carries data");
`endif

endmodule

@@ tb/tb_ethers_line_mac_parser.sv @@
// testbench for the ethers line mac address parser: directed and random lines against a predictor
module tb_ethers_line_mac_parser;
	import elmp_pkg::*;

	localparam int RANDOM_CHARS = 1650;
	localparam int PAUSE_EVERY  = 500;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 16;

	// one pending request for the character channel, or a marker that holds the feed
	// until every predicted result has come back
	typedef struct {
		bit          pause;
		logic [7:0]  c;
		int unsigned gap;
	} char_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        ch_valid = 1'b0;
	logic        ch_stall;
	logic [7:0]  ch = 8'h00;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        kind;
	logic [7:0]  out_char;
	logic        status;
	logic [47:0] mac_address;

	char_req_t   char_queue[$];
	res_t        parsed_results[$];

	// driver and monitor bookkeeping
	char_req_t   req;
	bit          ch_held = 1'b0;
	int unsigned gap_left = 0;
	bit          feed_calm = 1'b0;
	int unsigned stall_left = 0;
	bit          drain_calm = 1'b0;
	int          fail_count = 0;
	int          cycle_count = 0;
	int          random_chars = 0;

	// predictor state, mirrors the parser's line state
	phase_t      ph;
	logic [2:0]  grp_idx;
	logic [8:0]  grp_val;
	bit          grp_sign;
	bit          grp_neg;
	bit          grp_digit;
	bit          grp_oddws;
	logic [1:0]  grp_first;
	logic [47:0] addr;

	ethers_line_mac_parser i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.ch_valid    (ch_valid),
		.ch_stall    (ch_stall),
		.ch          (ch),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.kind        (kind),
		.out_char    (out_char),
		.status      (status),
		.mac_address (mac_address)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------
	// character classes
	// ---------------------------------------------------------------
	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic bit is_odd_ws(logic [7:0] c);
		return c == CH_VT || c == CH_FF || c == CH_CR;
	endfunction

	function automatic bit is_ws(logic [7:0] c);
		return is_blank(c) || is_odd_ws(c) || c == CH_NL;
	endfunction

	// hex digit value, -1 for anything else (bytes above 127 included)
	function automatic int hex_of(logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c) - int'("0");
		if (c >= "a" && c <= "f")
			return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F")
			return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	// ---------------------------------------------------------------
	// line parser prediction
	// ---------------------------------------------------------------
	task automatic clear_line_state();
		ph        = PH_LEAD;
		grp_idx   = 3'd0;
		grp_val   = 9'd0;
		grp_sign  = 1'b0;
		grp_neg   = 1'b0;
		grp_digit = 1'b0;
		grp_oddws = 1'b0;
		grp_first = FC_COLON;
		addr      = 48'd0;
	endtask

	task automatic emit_status(bit fail);
		res_t r;
		r.kind     = 1'b1;
		r.out_char = 8'h00;
		r.status   = fail;
		r.mac      = fail ? 48'd0 : addr;
		parsed_results.push_back(r);
		ph = PH_DONE;
	endtask

	task automatic emit_host_char(logic [7:0] c);
		res_t r;
		r.kind     = 1'b0;
		r.out_char = c;
		r.status   = 1'b0;
		r.mac      = 48'd0;
		parsed_results.push_back(r);
	endtask

	task automatic store_byte(logic [7:0] v);
		addr = {addr[39:0], v};
	endtask

	// magnitude saturates at 256 so overflow stays visible
	task automatic add_digit(int d);
		int v;
		v = int'(grp_val) * 16 + d;
		grp_val = (v > 256) ? 9'd256 : v[8:0];
		grp_digit = 1'b1;
	endtask

	task automatic start_next_group();
		grp_idx   = grp_idx + 3'd1;
		grp_val   = 9'd0;
		grp_sign  = 1'b0;
		grp_neg   = 1'b0;
		grp_digit = 1'b0;
		grp_oddws = 1'b0;
		grp_first = FC_COLON;
		ph        = PH_FIRST;
	endtask

	// the number of the current group stops at character c
	task automatic close_group(logic [7:0] c);
		bit last;
		bit bad;
		bit term;
		last = grp_idx >= LAST_GROUP;
		if (grp_digit) begin
			bad  = grp_val > 9'd255 || (grp_neg && grp_val != 9'd0);
			term = last ? is_blank(c) : (c == CH_COLON);
			if (bad || !term) begin
				emit_status(1'b1);
			end else begin
				store_byte(grp_val[7:0]);
				if (!last)
					start_next_group();
				else
					ph = PH_HSKIP;
			end
		end else if (!last) begin
			// empty group passes only when it is a bare colon
			if (grp_first != FC_COLON) begin
				emit_status(1'b1);
			end else begin
				store_byte(8'h00);
				start_next_group();
			end
		end else if (grp_first != FC_BLANK || grp_sign) begin
			emit_status(1'b1);
		end else begin
			// empty sixth group: parsing resumes at the stopping character
			store_byte(8'h00);
			if (grp_oddws || is_ws(c)) begin
				emit_status(1'b0);
			end else begin
				ph = PH_HOST;
				emit_host_char(c);
			end
		end
	endtask

	task automatic open_digits(int d);
		add_digit(d);
		ph = (d == 0) ? PH_ZERO : PH_DIG;
	endtask

	task automatic group_char(logic [7:0] c);
		int d;
		d = hex_of(c);
		case (ph)
			PH_WS: begin
				if (is_blank(c)) begin
				end else if (is_odd_ws(c)) begin
					grp_oddws = 1'b1;
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					grp_sign = 1'b1;
					if (c == CH_MINUS)
						grp_neg = 1'b1;
					ph = PH_SIGN;
				end else if (d >= 0) begin
					open_digits(d);
				end else begin
					close_group(c);
				end
			end
			PH_SIGN: begin
				if (d >= 0)
					open_digits(d);
				else
					close_group(c);
			end
			PH_ZERO: begin
				if (c == CH_X_LO || c == CH_X_UP) begin
					ph = PH_X;
				end else if (d >= 0) begin
					add_digit(d);
					ph = PH_DIG;
				end else begin
					close_group(c);
				end
			end
			PH_X: begin
				// a prefix with no digit after it fails the line
				if (d >= 0) begin
					add_digit(d);
					ph = PH_DIG;
				end else begin
					emit_status(1'b1);
				end
			end
			default: begin
				if (d >= 0)
					add_digit(d);
				else
					close_group(c);
			end
		endcase
	endtask

	// one accepted character: advance the predicted line state
	task automatic parse_char(logic [7:0] c);
		case (ph)
			PH_LEAD, PH_FIRST: begin
				if (!(ph == PH_LEAD && is_blank(c))) begin
					grp_first = (c == CH_COLON) ? FC_COLON :
						(is_blank(c) ? FC_BLANK : FC_OTHER);
					ph = PH_WS;
					group_char(c);
				end
			end
			PH_WS, PH_SIGN, PH_ZERO, PH_X, PH_DIG:
				group_char(c);
			PH_HSKIP: begin
				if (is_blank(c)) begin
				end else if (is_ws(c)) begin
					emit_status(1'b0);
				end else begin
					ph = PH_HOST;
					emit_host_char(c);
				end
			end
			PH_HOST: begin
				if (is_ws(c))
					emit_status(1'b0);
				else
					emit_host_char(c);
			end
			default: begin
			end
		endcase
		// newline always restarts the line
		if (c == CH_NL)
			clear_line_state();
	endtask

	// ---------------------------------------------------------------
	// stimulus building
	// ---------------------------------------------------------------
	task automatic push_char(logic [7:0] c);
		char_req_t r;
		r.pause = 1'b0;
		r.c     = c;
		r.gap   = feed_calm ? 0 : $urandom_range(0, 8);
		char_queue.push_back(r);
	endtask

	task automatic push_pause();
		char_req_t r;
		r.pause = 1'b1;
		r.c     = 8'h00;
		r.gap   = 0;
		char_queue.push_back(r);
	endtask

	task automatic push_str(string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endtask

	function automatic logic [7:0] hex_char(int v);
		bit up;
		up = ($urandom_range(0, 1) != 0);
		if (v < 10)
			return 8'(int'("0") + v);
		return 8'((up ? int'("A") : int'("a")) + v - 10);
	endfunction

	function automatic logic [7:0] pick_ws(bit blank_only);
		case ($urandom_range(0, blank_only ? 1 : 4))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_VT;
			3: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	// hex digits of v, one or two (three when v is above 255), maybe a leading zero
	task automatic push_hex(int v);
		if ($urandom_range(0, 3) == 0)
			push_char("0");
		if (v > 255)
			push_char(hex_char((v >> 8) & 15));
		if (v > 15)
			push_char(hex_char((v >> 4) & 15));
		push_char(hex_char(v & 15));
	endtask

	// one line in ethers format; spoil breaks one group in one of several ways
	task automatic push_entry_line(bit spoil);
		int bad_g;
		int bad_k;
		int v;
		int n;
		logic [7:0] c;
		bad_g = spoil ? $urandom_range(0, 5) : 7;
		bad_k = $urandom_range(0, 5);
		n = $urandom_range(0, 2);
		for (int i = 0; i < n; i++)
			push_char(pick_ws(1'b1));
		for (int g = 0; g < 6; g++) begin
			if (g == bad_g) begin
				case (bad_k)
					0: begin
						// magnitude above 255
						push_hex($urandom_range(256, 4095));
					end
					1: begin
						// minus on a nonzero value
						push_char(CH_MINUS);
						push_hex($urandom_range(1, 255));
					end
					2: begin
						// prefix with no digit after it
						push_char("0");
						push_char($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
						push_char($urandom_range(0, 1) ? "g" : CH_COLON);
					end
					3: begin
						// sign with no digits
						push_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
					end
					4: begin
						// wrong terminator
						push_hex($urandom_range(0, 255));
						push_char(g < 5 ? pick_ws(1'b1) : CH_COLON);
						continue;
					end
					default: begin
						push_hex($urandom_range(0, 255));
						push_char(8'($urandom_range(0, 255)));
					end
				endcase
				push_char(g < 5 ? CH_COLON : pick_ws(1'b1));
			end else if ($urandom_range(0, 7) == 0) begin
				// empty group: a bare colon, or for the sixth a blank that runs into the name
				if (g < 5) begin
					push_char(CH_COLON);
				end else begin
					push_char(pick_ws(1'b1));
					if ($urandom_range(0, 3) == 0)
						push_char(pick_ws(1'b0));
				end
			end else begin
				v = $urandom_range(0, 255);
				if ($urandom_range(0, 3) == 0)
					push_char(pick_ws(1'b0));
				case ($urandom_range(0, 7))
					0: push_char(CH_PLUS);
					1: begin
						push_char(CH_MINUS);
						v = 0;
					end
					default: begin
					end
				endcase
				if ($urandom_range(0, 3) == 0) begin
					push_char("0");
					push_char($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
				end
				push_hex(v);
				push_char(g < 5 ? CH_COLON : pick_ws(1'b1));
			end
		end
		// blanks before the hostname, then the hostname itself
		n = $urandom_range(0, 2);
		for (int i = 0; i < n; i++)
			push_char(pick_ws(1'b1));
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			push_char($urandom_range(0, 3) == 0 ? 8'($urandom_range(128, 255)) :
				8'($urandom_range(33, 126)));
		// optional ending whitespace and trailing junk
		if ($urandom_range(0, 3) != 0) begin
			push_char(pick_ws(1'b0));
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++) begin
				c = 8'($urandom_range(0, 255));
				push_char(c == CH_NL ? "z" : c);
			end
		end
		push_char(CH_NL);
	endtask

	// random bytes, either anything or drawn from the characters the parser cares about
	task automatic push_noise_line();
		string pool;
		int n;
		bit wide;
		pool = "0123456789abcdefABCDEFxX:+- \t";
		n = $urandom_range(0, 12);
		wide = ($urandom_range(0, 1) != 0);
		for (int i = 0; i < n; i++)
			push_char(wide ? 8'($urandom_range(0, 255)) :
				pool[$urandom_range(0, pool.len() - 1)]);
		push_char(CH_NL);
	endtask

	// ---------------------------------------------------------------
	// driver: one request at a time from the pending queue
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			ch_valid <= 1'b0;
		end else begin
			if (ch_valid && !ch_stall) begin
				parse_char(ch);
				ch_held = 1'b0;
			end
			if (!ch_held) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (char_queue.size() > 0) begin
					if (char_queue[0].pause) begin
						// hold the feed until the result side has caught up
						if (parsed_results.size() == 0)
							void'(char_queue.pop_front());
					end else begin
						req = char_queue.pop_front();
						ch <= req.c;
						ch_held = 1'b1;
						gap_left = req.gap;
					end
				end
			end
			ch_valid <= ch_held;
		end
	end

	// ---------------------------------------------------------------
	// monitor: random stall per result, compare against oldest prediction
	// ---------------------------------------------------------------
	task automatic check_result();
		res_t e;
		if (parsed_results.size() == 0) begin
			$error("result with nothing expected: kind %0d out_char %h status %0d mac %h",
				kind, out_char, status, mac_address);
			fail_count++;
		end else begin
			e = parsed_results.pop_front();
			if (kind !== e.kind) begin
				$error("kind: expected %0d, got %0d", e.kind, kind);
				fail_count++;
			end
			if (out_char !== e.out_char) begin
				$error("out_char: expected %h, got %h", e.out_char, out_char);
				fail_count++;
			end
			if (status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, status);
				fail_count++;
			end
			if (mac_address !== e.mac) begin
				$error("mac_address: expected %h, got %h", e.mac, mac_address);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				check_result();
				// now and then switch between stalling and a stall-free stretch
				if ($urandom_range(0, 39) == 0)
					drain_calm = !drain_calm;
				stall_left = drain_calm ? 0 : $urandom_range(0, 8);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			res_stall <= (stall_left > 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ethers_line_mac_parser test failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus and end of run
	// ---------------------------------------------------------------
	initial begin
		clear_line_state();

		// directed: extreme bytes on their own, then one line that walks a negative
		// zero, a signed value, a 0x prefix, a bare colon, whitespace inside a group
		// and an empty sixth group with a carriage return, which ends with an empty name
		push_char(8'hFF);
		push_char(CH_NL);
		push_char(8'h00);
		push_char(CH_NL);
		push_str(" -0:+FF:0x1a::");
		push_char(CH_TAB);
		push_char(CH_VT);
		push_str("1:");
		push_char(CH_TAB);
		push_char(CH_CR);
		push_str("h");
		push_char(CH_NL);
		push_pause();

		// random lines: mostly well formed, some spoiled, some noise
		while (random_chars < RANDOM_CHARS) begin
			int before_n;
			int pick;
			before_n = char_queue.size();
			if ($urandom_range(0, 4) == 0)
				feed_calm = !feed_calm;
			pick = $urandom_range(0, 19);
			if (pick < 11)
				push_entry_line(1'b0);
			else if (pick < 16)
				push_entry_line(1'b1);
			else
				push_noise_line();
			if ((random_chars / PAUSE_EVERY) !=
				((random_chars + char_queue.size() - before_n) / PAUSE_EVERY))
				push_pause();
			random_chars += char_queue.size() - before_n;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (char_queue.size() != 0 || ch_held || parsed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && parsed_results.size() == 0) begin
			$display("ethers_line_mac_parser test passed");
		end else begin
			$display("ethers_line_mac_parser test failed");
		end
		$finish;
	end

endmodule
